@@ design/gbn_pkg.sv @@
`default_nettype none
package gbn_pkg;

    // fixed field widths of the command and result transactions
    localparam int SEQ_W      = 32;
    localparam int PAY_W      = 12;
    localparam int SLOT_OUT_W = 5;
    localparam int FREED_W    = 5;
    localparam int TICK_W     = 16;
    localparam int WSIZE_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // a retransmission burst never exceeds this many results
    localparam int RESULT_CAP = 16;
    localparam int RUN_W      = $clog2(RESULT_CAP + 1);

    // parameter defaults
    localparam int MAX_WINDOW_DEF  = 16;
    localparam int STORE_DEPTH_DEF = 32;
    localparam int LENGTH_BITS_DEF = 12;

    // register reset values
    localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST = WSIZE_W'(16);
    localparam logic [TICK_W-1:0]  TIMEOUT_RST     = TICK_W'(10);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_SEND  = 2'd1,
        OP_ACK   = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_SEND  = 2'd1,
        KIND_RETX  = 2'd2,
        KIND_ACK   = 2'd3
    } kind_t;

    typedef struct packed {
        op_t                op;
        logic [PAY_W-1:0]   payload_length;
        logic [SEQ_W-1:0]   ack_number;
        logic               ack_ok;
    } in_t;

    typedef struct packed {
        kind_t                 kind;
        logic                  refused;
        logic [SEQ_W-1:0]      seq_number;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [PAY_W-1:0]      send_length;
        logic [FREED_W-1:0]    freed_count;
        logic                  last_of_run;
    } out_t;

endpackage
`default_nettype wire

@@ design/go_back_n_send_window.sv @@
`default_nettype none
// Go-Back-N sender window: write, send, ack and tick events on one command port.
// Write and ack results are registered and show the next cycle; a tick gives no result of its own.
// A send result passes the registered read of the payload length memory, then the result register.
// A timeout tick emits its run of up to 16 retransmissions one per cycle, busy meanwhile.
// Reset: window base and both send counters to one, timer stopped, registers to defaults;
// the length memory is not cleared. The receiver cannot stall results.
// STORE_DEPTH is taken as a power of two, slots being the low sequence bits.
module go_back_n_send_window
    import gbn_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire in_t                   cmd,
    output logic                       result_valid,
    output out_t                       result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W = $clog2(STORE_DEPTH);
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int CAP_W  = $clog2(STORE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SEND = 3'b010,
        ST_RETX = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [SEQ_W-1:0]  window_base_reg, window_base_next;
    logic [SEQ_W-1:0]  next_to_send_reg, next_to_send_next;
    logic [SEQ_W-1:0]  next_to_write_reg, next_to_write_next;
    logic              timer_running_reg, timer_running_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic [WSIZE_W-1:0] window_size_reg, window_size_next;
    logic [TICK_W-1:0] timeout_reg, timeout_next;
    logic [RUN_W-1:0]  retx_left_reg, retx_left_next;
    logic              valid_reg, valid_next;
    logic [SEQ_W-1:0]  retx_seq_reg, retx_seq_next;
    out_t              out_reg, out_next;

    logic [WIN_W-1:0]  win;
    logic [WIN_W:0]    win_dbl;
    logic [CAP_W-1:0]  cap;
    logic [SEQ_W-1:0]  write_span;
    logic [SEQ_W-1:0]  send_span;
    logic [SEQ_W-1:0]  ack_off;
    logic [SEQ_W-1:0]  ack_plus;
    logic [SEQ_W-1:0]  retx_seq_plus;
    logic [RUN_W-1:0]  run;
    logic [TICK_W-1:0] limit;
    logic [TICK_W-1:0] elapsed_inc;
    logic              write_full;
    logic              send_refused;
    logic              ack_taken;

    logic                   mem_we;
    logic [SLOT_W-1:0]      mem_waddr;
    logic [LENGTH_BITS-1:0] mem_wdata;
    logic                   mem_re;
    logic [SLOT_W-1:0]      mem_raddr;
    logic [LENGTH_BITS-1:0] mem_rdata;

    gbn_len_store #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (LENGTH_BITS)
    ) u_len_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // effective window and write capacity
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win = WIN_W'(1);
        end
        else if (32'(window_size_reg) > MAX_WINDOW)
        begin
            win = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            win = WIN_W'(window_size_reg);
        end
        win_dbl = {win, 1'b0};
        if (32'(win_dbl) > STORE_DEPTH)
        begin
            cap = CAP_W'(STORE_DEPTH);
        end
        else
        begin
            cap = CAP_W'(win_dbl);
        end
    end

    // modular distances from the window base
    assign write_span    = next_to_write_reg - window_base_reg;
    assign send_span     = next_to_send_reg - window_base_reg;
    assign ack_off       = cmd.ack_number - window_base_reg;
    assign ack_plus      = cmd.ack_number + 32'd1;
    assign retx_seq_plus = retx_seq_reg + 32'd1;
    assign write_full    = write_span >= 32'(cap);
    assign send_refused  = (next_to_send_reg == next_to_write_reg) || (send_span >= 32'(win));
    assign ack_taken     = cmd.ack_ok && (ack_off < send_span);
    assign run           = (send_span > 32'(RESULT_CAP)) ? RUN_W'(RESULT_CAP)
                                                         : RUN_W'(send_span);
    assign limit         = (timeout_reg == '0) ? TICK_W'(1) : timeout_reg;
    assign elapsed_inc   = (elapsed_reg != '1) ? elapsed_reg + TICK_W'(1) : elapsed_reg;

    // memory write side: only app writes
    assign mem_waddr = next_to_write_reg[SLOT_W-1:0];
    assign mem_wdata = LENGTH_BITS'(cmd.payload_length);

    // event handling and retransmission sequencing
    always_comb
    begin
        state_next         = state_reg;
        window_base_next   = window_base_reg;
        next_to_send_next  = next_to_send_reg;
        next_to_write_next = next_to_write_reg;
        timer_running_next = timer_running_reg;
        elapsed_next       = elapsed_reg;
        retx_left_next     = retx_left_reg;
        retx_seq_next      = retx_seq_reg;
        out_next           = out_reg;
        valid_next         = 1'b0;
        mem_we             = 1'b0;
        mem_re             = 1'b0;
        mem_raddr          = window_base_reg[SLOT_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.op)
                        OP_WRITE:
                        begin
                            out_next.kind        = KIND_WRITE;
                            out_next.refused     = write_full;
                            out_next.seq_number  = next_to_write_reg;
                            out_next.slot_index  =
                                SLOT_OUT_W'(next_to_write_reg[SLOT_W-1:0]);
                            out_next.send_length = '0;
                            out_next.freed_count = '0;
                            out_next.last_of_run = 1'b1;
                            valid_next           = 1'b1;
                            if (!write_full)
                            begin
                                mem_we             = 1'b1;
                                next_to_write_next = next_to_write_reg + 32'd1;
                            end
                        end
                        OP_SEND:
                        begin
                            // length arrives from the memory next cycle
                            out_next.kind        = KIND_SEND;
                            out_next.refused     = send_refused;
                            out_next.seq_number  = next_to_send_reg;
                            out_next.slot_index  =
                                SLOT_OUT_W'(next_to_send_reg[SLOT_W-1:0]);
                            out_next.send_length = '0;
                            out_next.freed_count = '0;
                            out_next.last_of_run = 1'b1;
                            mem_re               = 1'b1;
                            mem_raddr            = next_to_send_reg[SLOT_W-1:0];
                            state_next           = ST_SEND;
                            if (!send_refused)
                            begin
                                next_to_send_next = next_to_send_reg + 32'd1;
                                if (window_base_reg == next_to_send_reg)
                                begin
                                    timer_running_next = 1'b1;
                                    elapsed_next       = '0;
                                end
                            end
                        end
                        OP_ACK:
                        begin
                            out_next.kind        = KIND_ACK;
                            out_next.refused     = !ack_taken;
                            out_next.seq_number  = '0;
                            out_next.slot_index  = '0;
                            out_next.send_length = '0;
                            out_next.freed_count =
                                ack_taken ? FREED_W'(ack_off + 32'd1) : '0;
                            out_next.last_of_run = 1'b1;
                            valid_next           = 1'b1;
                            if (ack_taken)
                            begin
                                window_base_next   = ack_plus;
                                elapsed_next       = '0;
                                timer_running_next = (ack_plus != next_to_send_reg);
                            end
                        end
                        OP_TICK:
                        begin
                            if (timer_running_reg)
                            begin
                                if (elapsed_inc >= limit)
                                begin
                                    elapsed_next = '0;
                                    if (run != '0)
                                    begin
                                        mem_re         = 1'b1;
                                        retx_seq_next  = window_base_reg;
                                        retx_left_next = run;
                                        state_next     = ST_RETX;
                                    end
                                end
                                else
                                begin
                                    elapsed_next = elapsed_inc;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEND:
            begin
                out_next.send_length = out_reg.refused ? '0 : PAY_W'(mem_rdata);
                valid_next           = 1'b1;
                state_next           = ST_IDLE;
            end
            ST_RETX:
            begin
                // emit one stored sequence, fetch the following one
                out_next.kind        = KIND_RETX;
                out_next.refused     = 1'b0;
                out_next.seq_number  = retx_seq_reg;
                out_next.slot_index  = SLOT_OUT_W'(retx_seq_reg[SLOT_W-1:0]);
                out_next.send_length = PAY_W'(mem_rdata);
                out_next.freed_count = '0;
                out_next.last_of_run = (retx_left_reg == RUN_W'(1));
                valid_next           = 1'b1;
                mem_re               = 1'b1;
                mem_raddr            = retx_seq_plus[SLOT_W-1:0];
                retx_seq_next        = retx_seq_plus;
                retx_left_next       = retx_left_reg - RUN_W'(1);
                if (retx_left_reg == RUN_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration write transactions
    always_comb
    begin
        window_size_next = window_size_reg;
        timeout_next     = timeout_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_WINDOW_SIZE)
            begin
                window_size_next = cfg_data[WSIZE_W-1:0];
            end
            else if (cfg_index == CFG_TIMEOUT_TICKS)
            begin
                timeout_next = cfg_data[TICK_W-1:0];
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            window_base_reg   <= 32'd1;
            next_to_send_reg  <= 32'd1;
            next_to_write_reg <= 32'd1;
            timer_running_reg <= 1'b0;
            elapsed_reg       <= '0;
            window_size_reg   <= WINDOW_SIZE_RST;
            timeout_reg       <= TIMEOUT_RST;
            retx_left_reg     <= '0;
            valid_reg         <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            window_base_reg   <= window_base_next;
            next_to_send_reg  <= next_to_send_next;
            next_to_write_reg <= next_to_write_next;
            timer_running_reg <= timer_running_next;
            elapsed_reg       <= elapsed_next;
            window_size_reg   <= window_size_next;
            timeout_reg       <= timeout_next;
            retx_left_reg     <= retx_left_next;
            valid_reg         <= valid_next;
        end
    end

    // result payload and retransmission pointer
    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        retx_seq_reg <= retx_seq_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign result       = out_reg;
    assign cfg_ready    = 1'b1;

`ifndef SYNTHESIS
    // a retransmission run continues with the next sequence until its last result
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == KIND_RETX && !result.last_of_run) |=>
        (result_valid && result.kind == KIND_RETX &&
         result.seq_number == $past(result.seq_number) + 32'd1))
        else $error("retransmission run broken");

    // every other result closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind != KIND_RETX) |-> result.last_of_run)
        else $error("single result without last_of_run");

    // a send shows its result after the memory read cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op == OP_SEND) |=>
        (!result_valid ##1 (result_valid && result.kind == KIND_SEND)))
        else $error("send result timing");

    // outstanding sequences stay within the window and below the write pointer
    assert property (@(posedge clk) disable iff (!rst_n)
        (send_span <= 32'(MAX_WINDOW)) && (send_span <= write_span) &&
        (write_span <= 32'(STORE_DEPTH)))
        else $error("window pointers out of order");
`endif

endmodule
`default_nettype wire

@@ design/gbn_len_store.sv @@
`default_nettype none
module gbn_len_store #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 12
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire
